>>> src/olist_pkg.sv
package olist_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  // Operation codes of a request.
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  // Status codes of a response.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Commands broadcast to the row of cells.
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_WRITE  = 2'd1;
  localparam logic [1:0] CELL_SHIFT  = 2'd2;
  localparam logic [1:0] CELL_ROTATE = 2'd3;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       start;
    idx_t       idx;
    val_t       key;
  } cell_ctrl_t;

  // Low six bits of a position, zero extended for a small list.
  function automatic logic [5:0] idx_field(idx_t x);
    logic [5:0] r;
    r = '0;
    for (int b = 0; b < IDX_W; b++) begin
      if (b < 6) r[b] = x[b];
    end
    return r;
  endfunction

  // Low seven bits of a count, zero extended for a small list.
  function automatic logic [6:0] cnt_field(cnt_t x);
    logic [6:0] r;
    r = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (b < 7) r[b] = x[b];
    end
    return r;
  endfunction

endpackage

>>> src/olist_if.sv
interface olist_req_if import olist_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface olist_resp_if import olist_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] item_value;
  logic [5:0]         item_index;
  logic [6:0]         count;
  logic               last;

  modport source (output valid, output status, output item_value, output item_index,
                  output count, output last, input ready);
  modport sink   (input valid, input status, input item_value, input item_index,
                  input count, input last, output ready);
endinterface

>>> src/ordered_list_delete_by_value.sv
// Append, unknown operation, full, empty and delete of an empty list: result in the cycle
// after the transaction; the next request is taken at the edge that takes that result.
// Delete: the search token walks one cell per cycle until a hit or the last entry; the match
// or miss answers once the response slot is free, a match shifting the row in that cycle.
// Dump: count results, one per cycle while taken, paced by the rotation of the cell row.
// Reset clears the entry count, state, response valid and search tokens; entries are not cleared.
module ordered_list_delete_by_value import olist_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  olist_req_if.sink    req,
  olist_resp_if.source resp
);

  cell_ctrl_t          ctrl;
  val_t                cell_val [CAPACITY];
  logic [CAPACITY-1:0] tok;
  logic [CAPACITY-1:0] hit;

  olist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .resp     (resp),
    .hit      (hit),
    .head_val (cell_val[0]),
    .ctrl     (ctrl)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    val_t next_val;
    logic tok_in;

    if (g == CAPACITY - 1) begin : g_tail
      assign next_val = '0;
    end else begin : g_body
      assign next_val = cell_val[g+1];
    end

    if (g == 0) begin : g_head
      assign tok_in = 1'b0;
    end else begin : g_link
      assign tok_in = tok[g-1];
    end

    olist_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .pos      (idx_t'(g)),
      .next_val (next_val),
      .head_val (cell_val[0]),
      .tok_in   (tok_in),
      .val      (cell_val[g]),
      .tok      (tok[g]),
      .hit      (hit[g])
    );
  end

endmodule

>>> src/olist_cell.sv
module olist_cell import olist_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  idx_t       pos,
  input  val_t       next_val,
  input  val_t       head_val,
  input  logic       tok_in,
  output val_t       val,
  output logic       tok,
  output logic       hit
);

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CELL_WRITE: begin
        if (pos == ctrl.idx) val <= ctrl.key;
      end
      CELL_SHIFT: begin
        if (pos >= ctrl.idx) val <= next_val;
      end
      CELL_ROTATE: begin
        // The last occupied cell takes the head so the list comes back whole.
        if (pos == ctrl.idx) begin
          val <= head_val;
        end else if (pos < ctrl.idx) begin
          val <= next_val;
        end
      end
      default: ;
    endcase
  end

  // The search token walks one cell per cycle from the head of the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (ctrl.start) begin
      tok <= (pos == '0);
    end else begin
      tok <= tok_in;
    end
  end

  assign hit = tok & (val == ctrl.key);

endmodule

>>> src/olist_ctrl.sv
module olist_ctrl import olist_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  olist_req_if.sink           req,
  olist_resp_if.source        resp,
  input  logic [CAPACITY-1:0] hit,
  input  val_t                head_val,
  output cell_ctrl_t          ctrl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_MISS  = 3'd3;
  localparam logic [2:0] S_DUMP  = 3'd4;

  logic [2:0] state, state_next;
  cnt_t       count, count_next;
  idx_t       pos, pos_next;
  val_t       key, key_next;

  logic       out_valid;
  logic [1:0] out_status;
  val_t       out_value;
  logic [5:0] out_index;
  logic [6:0] out_count;
  logic       out_last;

  logic       emit;
  logic [1:0] e_status;
  val_t       e_value;
  idx_t       e_index;
  cnt_t       e_count;
  logic       e_last;

  logic slot_free, accept, full, hit_any, at_last;
  idx_t last_idx;

  assign slot_free = !out_valid || resp.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign accept    = req.valid && req.ready;
  assign full      = (count == cnt_t'(CAPACITY));
  assign hit_any   = |hit;
  assign last_idx  = idx_t'(count - cnt_t'(1));
  assign at_last   = (pos == last_idx);

  always_comb begin
    state_next = state;
    count_next = count;
    pos_next   = pos;
    key_next   = key;
    emit       = 1'b0;
    e_status   = ST_DONE;
    e_value    = '0;
    e_index    = '0;
    e_count    = count;
    e_last     = 1'b1;
    ctrl.cmd   = CELL_HOLD;
    ctrl.start = 1'b0;
    ctrl.idx   = '0;
    ctrl.key   = key;

    case (state)
      S_IDLE: begin
        ctrl.key = req.value;
        if (accept) begin
          key_next = req.value;
          case (req.operation)
            OP_APPEND: begin
              emit = 1'b1;
              if (full) begin
                e_status = ST_FULL;
              end else begin
                ctrl.cmd   = CELL_WRITE;
                ctrl.idx   = idx_t'(count);
                count_next = count + cnt_t'(1);
                e_count    = count + cnt_t'(1);
              end
            end
            OP_DELETE: begin
              if (count == '0) begin
                emit     = 1'b1;
                e_status = ST_NOT_FOUND;
              end else begin
                ctrl.start = 1'b1;
                pos_next   = '0;
                state_next = S_SCAN;
              end
            end
            OP_DUMP: begin
              if (count == '0) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                pos_next   = '0;
                state_next = S_DUMP;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // The token sits on the cell at pos; the first hit is the match.
        if (hit_any) begin
          state_next = S_SHIFT;
        end else if (at_last) begin
          state_next = S_MISS;
        end else begin
          pos_next = pos + idx_t'(1);
        end
      end
      S_SHIFT: begin
        if (slot_free) begin
          ctrl.cmd   = CELL_SHIFT;
          ctrl.idx   = pos;
          count_next = count - cnt_t'(1);
          emit       = 1'b1;
          e_count    = count - cnt_t'(1);
          state_next = S_IDLE;
        end
      end
      S_MISS: begin
        if (slot_free) begin
          emit       = 1'b1;
          e_status   = ST_NOT_FOUND;
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          ctrl.cmd = CELL_ROTATE;
          ctrl.idx = last_idx;
          emit     = 1'b1;
          e_value  = head_val;
          e_index  = pos;
          e_last   = at_last;
          if (at_last) begin
            state_next = S_IDLE;
          end else begin
            pos_next = pos + idx_t'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    key <= key_next;
    if (emit) begin
      out_status <= e_status;
      out_value  <= e_value;
      out_index  <= idx_field(e_index);
      out_count  <= cnt_field(e_count);
      out_last   <= e_last;
    end
  end

  assign resp.valid      = out_valid;
  assign resp.status     = out_status;
  assign resp.item_value = out_value;
  assign resp.item_index = out_index;
  assign resp.count      = out_count;
  assign resp.last       = out_last;

endmodule

>>> src/olist_chk.sv
module olist_chk import olist_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               resp_valid,
  input logic               resp_ready,
  input logic [1:0]         status,
  input logic signed [31:0] item_value,
  input logic [5:0]         item_index,
  input logic [6:0]         count,
  input logic               last
);

  localparam logic [6:0] FULL_COUNT = 7'(CAPACITY);

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(status) && $stable(item_value)
      && $stable(item_index) && $stable(count) && $stable(last))
    else $error("response changed while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    resp_valid && (status == ST_FULL) |-> (count == FULL_COUNT) && last)
    else $error("full status with a list that is not full");

  a_empty_single: assert property (@(posedge clk) disable iff (rst)
    resp_valid && (status == ST_EMPTY) |-> (count == '0) && last && (item_value == '0)
      && (item_index == '0))
    else $error("empty status malformed");

  a_miss_single: assert property (@(posedge clk) disable iff (rst)
    resp_valid && (status == ST_NOT_FOUND) |-> last && (item_value == '0)
      && (item_index == '0))
    else $error("not found status malformed");

endmodule

bind ordered_list_delete_by_value olist_chk u_olist_chk (
  .clk        (clk),
  .rst        (rst),
  .resp_valid (resp.valid),
  .resp_ready (resp.ready),
  .status     (resp.status),
  .item_value (resp.item_value),
  .item_index (resp.item_index),
  .count      (resp.count),
  .last       (resp.last)
);

>>> dv/ordered_list_delete_by_value_tb.sv
`timescale 1ns / 1ps
module ordered_list_delete_by_value_tb;
  import olist_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 320;
  localparam int DRAIN_CYCLES = 100;
  localparam val_t FILL_BASE  = 32'sh5A5A_0000;
  localparam val_t VAL_MIN    = 32'sh8000_0000;
  localparam val_t VAL_MAX    = 32'sh7FFF_FFFF;

  typedef struct {
    logic [1:0] status;
    val_t       item_value;
    logic [5:0] item_index;
    logic [6:0] count;
    logic       last;
  } resp_t;

  typedef struct {
    logic [1:0] op;
    val_t       value;
    int         reps;
    bit         typed;
    logic [1:0] status;
    logic [6:0] count;
  } dir_row_t;

  logic clk;
  logic rst;

  olist_req_if  req ();
  olist_resp_if resp ();

  ordered_list_delete_by_value DUT (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .resp (resp)
  );

  // Shadow copy of the list and the responses still owed by the block.
  val_t     list_mem [CAPACITY];
  int       list_len;
  resp_t    responses_due [$];
  dir_row_t dir_tbl [24];
  int       errors;
  int       idle_cycles;
  int       burst_left;
  bit       hold_req;
  bit       hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one operation to the shadow list and queues the responses it causes.
  task automatic list_apply(input logic [1:0] op, input val_t value, input bit record);
    int    pos;
    int    i;
    resp_t r;
    r = '{ST_DONE, '0, '0, '0, 1'b1};
    pos = -1;
    case (op)
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = value;
          list_len++;
        end
      end
      OP_DELETE: begin
        for (i = 0; i < list_len && pos < 0; i++) begin
          if (list_mem[i] == value) pos = i;
        end
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
      OP_DUMP: begin
        if (list_len == 0) r.status = ST_EMPTY;
      end
      default: ;
    endcase
    r.count = 7'(list_len);
    if (op == OP_DUMP && list_len > 0) begin
      for (i = 0; i < list_len; i++) begin
        r.item_value = list_mem[i];
        r.item_index = 6'(i);
        r.last       = (i == list_len - 1);
        if (record) responses_due.push_back(r);
      end
    end else if (record) begin
      responses_due.push_back(r);
    end
  endtask

  // Offers one request, inserting an idle gap whenever the current burst runs out.
  task automatic send_request(input logic [1:0] op, input val_t value, input bit typed,
                              input resp_t typed_resp);
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.value     <= value;
    do @(posedge clk); while (!req.ready);
    burst_left--;
    list_apply(op, value, !typed);
    if (typed) responses_due.push_back(typed_resp);
  endtask

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    resp_t exp_r;
    if (!rst && resp.valid && resp.ready) begin
      if (responses_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual status %0h value %0h",
                 $time, resp.status, resp.item_value);
      end else begin
        exp_r = responses_due.pop_front();
        check_field("status", 32'(exp_r.status), 32'(resp.status));
        check_field("item_value", exp_r.item_value, resp.item_value);
        check_field("item_index", 32'(exp_r.item_index), 32'(resp.item_index));
        check_field("count", 32'(exp_r.count), 32'(resp.count));
        check_field("last", 32'(exp_r.last), 32'(resp.last));
      end
    end
  end

  // The response side stalls on its own pattern, with one long hold-off on request.
  initial begin
    int mode_left;
    int ready_pct;
    mode_left = 0;
    ready_pct = 100;
    resp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        resp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(16, 64);
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 50;
            2: ready_pct = 20;
            default: ready_pct = 90;
          endcase
        end
        mode_left--;
        resp.ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (resp.valid && resp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("ordered_list_delete_by_value_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int         r;
    int         k;
    int         n;
    int         phase;
    int         roll;
    int         dump_pct;
    int         del_pct;
    logic [1:0] op;
    val_t       value;
    resp_t      typed_resp;

    rst           = 1'b1;
    req.valid     = 1'b0;
    req.operation = OP_APPEND;
    req.value     = '0;
    list_len      = 0;
    burst_left    = 0;
    hold_req      = 1'b0;

    // Empty list, extreme values, duplicates, deletes at both ends, then a full list.
    dir_tbl = '{
      '{OP_DUMP,   32'sd0,           1,  1'b1, ST_EMPTY,     7'd0},
      '{OP_DELETE, 32'sd7,           1,  1'b1, ST_NOT_FOUND, 7'd0},
      '{OP_UNUSED, -32'sd1,          1,  1'b1, ST_DONE,      7'd0},
      '{OP_APPEND, VAL_MIN,          1,  1'b1, ST_DONE,      7'd1},
      '{OP_APPEND, VAL_MAX,          1,  1'b1, ST_DONE,      7'd2},
      '{OP_APPEND, 32'sd0,           1,  1'b0, ST_DONE,      7'd0},
      '{OP_APPEND, -32'sd1,          1,  1'b0, ST_DONE,      7'd0},
      '{OP_APPEND, 32'sd5,           1,  1'b0, ST_DONE,      7'd0},
      '{OP_APPEND, -32'sd1,          1,  1'b0, ST_DONE,      7'd0},
      '{OP_DUMP,   32'sd0,           1,  1'b0, ST_DONE,      7'd0},
      '{OP_DELETE, -32'sd1,          1,  1'b0, ST_DONE,      7'd0},
      '{OP_DELETE, 32'sd42,          1,  1'b1, ST_NOT_FOUND, 7'd5},
      '{OP_DELETE, VAL_MIN,          1,  1'b1, ST_DONE,      7'd4},
      '{OP_DELETE, -32'sd1,          1,  1'b1, ST_DONE,      7'd3},
      '{OP_DUMP,   32'sd0,           1,  1'b0, ST_DONE,      7'd0},
      '{OP_APPEND, FILL_BASE,        61, 1'b0, ST_DONE,      7'd0},
      '{OP_APPEND, 32'sd9,           1,  1'b1, ST_FULL,      7'd64},
      '{OP_DUMP,   32'sd0,           1,  1'b0, ST_DONE,      7'd0},
      '{OP_DELETE, FILL_BASE + 60,   1,  1'b1, ST_DONE,      7'd63},
      '{OP_APPEND, 32'sd9,           1,  1'b0, ST_DONE,      7'd0},
      '{OP_DELETE, VAL_MAX,          1,  1'b1, ST_DONE,      7'd63},
      '{OP_DELETE, 32'sd12345,       1,  1'b1, ST_NOT_FOUND, 7'd63},
      '{OP_DUMP,   32'sd0,           1,  1'b0, ST_DONE,      7'd0},
      '{OP_UNUSED, 32'sh1234_5678,   1,  1'b1, ST_DONE,      7'd63}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < $size(dir_tbl); r++) begin
      typed_resp = '{dir_tbl[r].status, '0, '0, dir_tbl[r].count, 1'b1};
      for (k = 0; k < dir_tbl[r].reps; k++) begin
        send_request(dir_tbl[r].op, val_t'(dir_tbl[r].value + k), dir_tbl[r].typed,
                     typed_resp);
      end
    end

    // Random traffic in phases that grow, shrink or churn the list.
    typed_resp = '{ST_DONE, '0, '0, '0, 1'b1};
    phase    = 1;
    dump_pct = 8;
    del_pct  = 65;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0 && n != 0) begin
        phase = $urandom_range(0, 2);
        case (phase)
          0: begin dump_pct = 6;  del_pct = 15; end
          1: begin dump_pct = 8;  del_pct = 65; end
          default: begin dump_pct = 12; del_pct = 40; end
        endcase
      end
      if (n == 120) hold_req = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 2) op = OP_UNUSED;
      else if (roll < 2 + dump_pct) op = OP_DUMP;
      else if (roll < 2 + dump_pct + del_pct) op = OP_DELETE;
      else op = OP_APPEND;

      if (op == OP_DELETE && list_len > 0 && $urandom_range(0, 3) != 0) begin
        value = list_mem[$urandom_range(0, list_len - 1)];
      end else if ($urandom_range(0, 2) == 0) begin
        // A narrow pool of values makes duplicates and repeated matches common.
        case ($urandom_range(0, 9))
          0: value = VAL_MIN;
          1: value = VAL_MAX;
          default: value = $urandom_range(0, 8) - 4;
        endcase
      end else begin
        value = $urandom;
      end
      send_request(op, value, 1'b0, typed_resp);
    end

    req.valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ordered_list_delete_by_value_tb: PASS");
    end else begin
      $display("ordered_list_delete_by_value_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> ordered_list_delete_by_value.f
src/olist_pkg.sv
src/olist_if.sv
src/olist_cell.sv
src/olist_ctrl.sv
src/ordered_list_delete_by_value.sv
src/olist_chk.sv
dv/ordered_list_delete_by_value_tb.sv
